@@ design/hs_pkg.sv @@
// Package for the heap_sort block: transaction structs, cell control and FSM state type.
// Has no dependencies. Used by hs_cell and heap_sort.
package hs_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;

    // One input transaction.
    typedef struct packed {
        t_word value;
        logic  is_last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        t_word sorted_value;
        logic  end_of_set;
        logic  overflowed;
    } t_out_item;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

@@ design/hs_cell.sv @@
// One cell of the sorting chain: holds one element and trades with its neighbors.
// Depends on hs_pkg.
module hs_cell (
    input  logic               i_clk,
    input  hs_pkg::t_cell_ctrl i_ctrl,
    input  hs_pkg::t_word      i_x,
    input  logic               i_occ,
    input  logic               i_prev_keep,
    input  hs_pkg::t_word      i_prev_val,
    input  hs_pkg::t_word      i_next_val,
    output logic               o_keep,
    output hs_pkg::t_word      o_val
);
    import hs_pkg::*;

    t_word r_val;
    t_word n_val;

    // Keep the held element if the cell is occupied and the element is not larger than the incoming one
    assign o_keep = i_occ && (r_val <= i_x);
    assign o_val  = r_val;

    // Choose: hold, take the new element, or take a neighbor's element
    always_comb begin
        n_val = r_val;
        if (i_ctrl.insert) begin
            if (o_keep) begin
                n_val = r_val;
            end else if (i_prev_keep) begin
                n_val = i_x;
            end else begin
                n_val = i_prev_val;
            end
        end else if (i_ctrl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ design/heap_sort.sv @@
// Top level of the heap_sort block: control FSM, element count and the chain of cells.
// Depends on hs_pkg and hs_cell.
//
// The block keeps the set sorted while it loads: a row of MAX_ELEMENTS cells holds the elements
// in ascending order, and each input transaction is inserted as it is accepted, so elements are
// accepted back to back. The transaction marked is_last closes the set; from the next cycle
// the chain shifts toward cell 0 and emits one result per held element, one per cycle while
// i_stall is low, smallest first, with end_of_set on the last. While results drain, o_stall is
// high; input resumes the cycle after the last result is taken. A set thus occupies the block
// for its load transactions, dropped ones included, and then for its results (longer if either
// side idles or stalls). Elements beyond MAX_ELEMENTS are dropped, and every result of that
// set carries overflowed.
module heap_sort #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hs_pkg::t_in_item  i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output hs_pkg::t_out_item o_out
);
    import hs_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    t_state     r_state;
    t_state     n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic       r_ovf;
    logic       n_ovf;
    logic       in_acc;
    logic       out_acc;
    logic       full;
    t_cell_ctrl ctrl;
    t_word      cell_val  [MAX_ELEMENTS];
    logic       cell_keep [MAX_ELEMENTS];

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign full    = (r_count == CNT_W'(MAX_ELEMENTS));

    // Advance state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && i_in.is_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_acc && (r_count == CNT_W'(1))) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Drive handshakes and cell control from state
    always_comb begin
        o_stall     = 1'b1;
        o_valid     = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall     = 1'b0;
                ctrl.insert = in_acc && !full;
            end
            ST_DRAIN: begin
                o_valid    = 1'b1;
                ctrl.shift = out_acc;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // Track element count and overflow flag
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.shift) begin
            n_count = r_count - CNT_W'(1);
        end
        if (in_acc && full) begin
            n_ovf = 1'b1;
        end
        if (out_acc && (r_count == CNT_W'(1))) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Build the chain of cells
    for (genvar gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
        logic  occ;
        logic  prev_keep;
        t_word prev_val;
        t_word next_val;

        assign occ = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_val  = cell_val[gi];
        end else begin : g_body
            assign prev_keep = cell_keep[gi-1];
            assign prev_val  = cell_val[gi-1];
        end

        if (gi == MAX_ELEMENTS - 1) begin : g_tail
            assign next_val = cell_val[gi];
        end else begin : g_mid
            assign next_val = cell_val[gi+1];
        end

        hs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_x         (i_in.value),
            .i_occ       (occ),
            .i_prev_keep (prev_keep),
            .i_prev_val  (prev_val),
            .i_next_val  (next_val),
            .o_keep      (cell_keep[gi]),
            .o_val       (cell_val[gi])
        );
    end

    // Present the head of the chain
    assign o_out.sorted_value = cell_val[0];
    assign o_out.end_of_set   = (r_count == CNT_W'(1));
    assign o_out.overflowed   = r_ovf;

    // Draining always has at least one element left
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("drain with empty chain");

    // Count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // Closing transaction starts the drain
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.is_last) |=> (r_state == ST_DRAIN))
        else $error("last element did not start drain");

    // Final result returns the block to an empty load state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.end_of_set) |=>
            (r_state == ST_LOAD && r_count == '0 && !r_ovf))
        else $error("state not cleared after end of set");

    // Head of the chain is not larger than the next cell while draining
    if (MAX_ELEMENTS > 1) begin : g_order_chk
        a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_DRAIN && r_count > CNT_W'(1)) |-> (cell_val[0] <= cell_val[1]))
            else $error("chain out of order");
    end

endmodule
